>>> hdl/acr_pkg.sv
// ----------------------------------------------------------------------------
// acr_pkg - shared definitions for the associative tag store
// Widths of the fixed port fields, parameter defaults, controller state
// encoding and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package acr_pkg;

  localparam int DEF_LINES    = 8;
  localparam int DEF_TAG_BITS = 16;

  localparam int TAG_PORT_W = 16;  // block_tag and evicted_tag ports
  localparam int IDX_PORT_W = 3;   // line_index port
  localparam int CNT_W      = 16;  // use counts and hit total

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_LOOKUP = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_COMMIT = 4'b1000
  } acr_state_t;

  typedef struct packed {
    logic capture;    // latch the incoming tag
    logic lookup;     // compare all lines, register the outcome
    logic scan_step;  // visit one line of the victim search
    logic commit;     // update the lines and load the result register
  } acr_cmd_t;

  typedef struct packed {
    logic full_miss;    // miss with every line valid: search for a victim
    logic scan_last;    // the line under scan is the last one
    logic out_blocked;  // result register full and stalled
  } acr_sts_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

endpackage

`default_nettype wire

>>> hdl/assoc_cache_tag_replacement.sv
// ----------------------------------------------------------------------------
// assoc_cache_tag_replacement - fully associative tag store, FIFO / LFU-LRU
// Top level: joins the sequencer and the datapath, drives the config port.
// ----------------------------------------------------------------------------
// Sequence: an accepted transaction has its tag captured and then its lookup
//   outcome registered; when every line is valid, a victim is searched, one
//   line per cycle; a commit then loads the result register once it is not
//   blocked. A new transaction is taken only after the commit; the sequence
//   runs over the single line read port.
// Reset: synchronous, clears valid bits, counts, ranks, the hit total and the
//   mode register at once; no clearing pass.
`default_nettype none

module assoc_cache_tag_replacement import acr_pkg::*; #(
  parameter int LINES    = DEF_LINES,
  parameter int TAG_BITS = DEF_TAG_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // configuration write channel
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic                  replace_mode,
  // request channel
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [TAG_PORT_W-1:0] block_tag,
  // result channel
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       hit,
  output logic [IDX_PORT_W-1:0]      line_index,
  output logic                       evicted,
  output logic [TAG_PORT_W-1:0]      evicted_tag,
  output logic [CNT_W-1:0]           hit_total
);

  acr_cmd_t cmd;
  acr_sts_t sts;

  // Mode writes must arrive only while idle; unchecked, taken every cycle.
  assign cfg_ready = 1'b1;

  // Sequencer: one transaction at a time; the result register lets the
  // next transaction start while the previous result is still stalled.
  acr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Line storage, compare, victim scan, update and result register.
  acr_datapath #(
    .LINES    (LINES),
    .TAG_BITS (TAG_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_mode    (replace_mode),
    .block_tag   (block_tag),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .hit         (hit),
    .line_index  (line_index),
    .evicted     (evicted),
    .evicted_tag (evicted_tag),
    .hit_total   (hit_total)
  );

endmodule

`default_nettype wire

>>> hdl/acr_ctrl.sv
// ----------------------------------------------------------------------------
// acr_ctrl - sequencer of the associative tag store
// Steps each transaction through lookup, optional victim scan and commit.
// ----------------------------------------------------------------------------
`default_nettype none

module acr_ctrl import acr_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire acr_sts_t sts,
  output acr_cmd_t      cmd
);

  acr_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    cmd           = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_next = sts.full_miss ? ST_SCAN : ST_COMMIT;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (!sts.out_blocked) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign in_stall = (state != ST_IDLE);

  a_accept_to_lookup: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == ST_LOOKUP))
    else $error("accepted transaction did not enter lookup");

  a_scan_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && !sts.scan_last) |=> (state == ST_SCAN))
    else $error("victim scan left before the last line");

  a_commit_waits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COMMIT && sts.out_blocked) |=> (state == ST_COMMIT))
    else $error("commit issued while the result register was blocked");

endmodule

`default_nettype wire

>>> hdl/acr_datapath.sv
// ----------------------------------------------------------------------------
// acr_datapath - line storage, lookup, victim scan and result register
// Holds tags, use counts and age ranks per line and applies the commands.
// ----------------------------------------------------------------------------
`default_nettype none

module acr_datapath import acr_pkg::*; #(
  parameter int LINES    = DEF_LINES,
  parameter int TAG_BITS = DEF_TAG_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire acr_cmd_t              cmd,
  output acr_sts_t                   sts,
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_mode,
  input  wire logic [TAG_PORT_W-1:0] block_tag,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       hit,
  output logic [IDX_PORT_W-1:0]      line_index,
  output logic                       evicted,
  output logic [TAG_PORT_W-1:0]      evicted_tag,
  output logic [CNT_W-1:0]           hit_total
);

  localparam int IDX_W = $clog2(LINES);
  localparam int FL_W  = $clog2(LINES + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LINES - 1);

  logic                repl_mode;
  logic [TAG_BITS-1:0] tag;
  logic                line_valid [LINES];
  logic [TAG_BITS-1:0] line_tag   [LINES];
  logic [CNT_W-1:0]    use_count  [LINES];
  logic [IDX_W-1:0]    age_rank   [LINES];
  logic [FL_W-1:0]     filled_lines;
  logic [CNT_W-1:0]    hits_seen;

  logic                hit_r, fill_r;
  logic [IDX_W-1:0]    sel, scan_idx;
  logic [CNT_W-1:0]    best_count;
  logic [IDX_W-1:0]    best_age;

  logic [TAG_BITS+TAG_PORT_W-1:0] tag_in_wide;
  logic [TAG_BITS+TAG_PORT_W-1:0] tag_out_wide;
  logic [IDX_W+IDX_PORT_W-1:0]    idx_out_wide;

  // Lookup: parallel compare, lowest-numbered match and free line.
  logic             any_match, any_free;
  logic [IDX_W-1:0] match_idx, free_idx;

  always_comb begin
    any_match = 1'b0;
    any_free  = 1'b0;
    match_idx = '0;
    free_idx  = '0;
    for (int i = LINES - 1; i >= 0; i--) begin
      if (line_valid[i] && line_tag[i] == tag) begin
        any_match = 1'b1;
        match_idx = IDX_W'(i);
      end
      if (!line_valid[i]) begin
        any_free = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  // One read port on the count/age/tag arrays: scan position or chosen line.
  logic [IDX_W-1:0]    rd_idx;
  logic [CNT_W-1:0]    rd_count;
  logic [IDX_W-1:0]    rd_age;
  logic [TAG_BITS-1:0] rd_tag;
  logic                better;

  assign rd_idx   = cmd.scan_step ? scan_idx : sel;
  assign rd_count = use_count[rd_idx];
  assign rd_age   = age_rank[rd_idx];
  assign rd_tag   = line_tag[rd_idx];

  always_comb begin
    if (repl_mode) begin
      better = (rd_count < best_count) || (rd_count == best_count && rd_age < best_age);
    end else begin
      better = (rd_age < best_age);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      repl_mode <= 1'b0;
    end else if (cfg_we) begin
      repl_mode <= cfg_mode;
    end
  end

  assign tag_in_wide = {{TAG_BITS{1'b0}}, block_tag};

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      tag <= tag_in_wide[TAG_BITS-1:0];
    end
    if (cmd.lookup) begin
      hit_r      <= any_match;
      fill_r     <= !any_match && any_free;
      sel        <= any_match ? match_idx : (any_free ? free_idx : '0);
      best_count <= use_count[0];
      best_age   <= age_rank[0];
      scan_idx   <= IDX_W'(1);
    end else if (cmd.scan_step) begin
      scan_idx <= scan_idx + 1'b1;
      if (better) begin
        sel        <= scan_idx;
        best_count <= rd_count;
        best_age   <= rd_age;
      end
    end
  end

  // Commit: new line state.
  logic                replace;
  logic [FL_W-1:0]     filled_m1;
  logic                valid_next [LINES];
  logic [TAG_BITS-1:0] tag_next   [LINES];
  logic [CNT_W-1:0]    count_next [LINES];
  logic [IDX_W-1:0]    age_next   [LINES];
  logic [CNT_W-1:0]    hits_next;

  assign replace   = !hit_r && !fill_r;
  assign filled_m1 = filled_lines - 1'b1;
  assign hits_next = hit_r ? sat_inc(hits_seen) : hits_seen;

  always_comb begin
    for (int i = 0; i < LINES; i++) begin
      valid_next[i] = line_valid[i];
      tag_next[i]   = line_tag[i];
      count_next[i] = use_count[i];
      age_next[i]   = age_rank[i];
      if (IDX_W'(i) == sel) begin
        if (hit_r) begin
          count_next[i] = sat_inc(use_count[i]);
          if (repl_mode) begin
            age_next[i] = filled_m1[IDX_W-1:0];
          end
        end else if (fill_r) begin
          valid_next[i] = 1'b1;
          tag_next[i]   = tag;
          count_next[i] = sat_inc(use_count[i]);
          age_next[i]   = IDX_W'(i);
        end else begin
          tag_next[i] = tag;
          age_next[i] = LAST_IDX;
          if (repl_mode) begin
            count_next[i] = CNT_W'(1);
          end
        end
      end else begin
        if ((hit_r || replace) && repl_mode) begin
          if (age_rank[i] > rd_age) begin
            age_next[i] = age_rank[i] - 1'b1;
          end
        end else if (replace) begin
          if (age_rank[i] != '0) begin
            age_next[i] = age_rank[i] - 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filled_lines <= '0;
      hits_seen    <= '0;
      for (int i = 0; i < LINES; i++) begin
        line_valid[i] <= 1'b0;
        use_count[i]  <= '0;
        age_rank[i]   <= '0;
      end
    end else if (cmd.commit) begin
      hits_seen <= hits_next;
      if (fill_r && filled_lines < FL_W'(LINES)) begin
        filled_lines <= filled_lines + 1'b1;
      end
      for (int i = 0; i < LINES; i++) begin
        line_valid[i] <= valid_next[i];
        use_count[i]  <= count_next[i];
        age_rank[i]   <= age_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      for (int i = 0; i < LINES; i++) begin
        line_tag[i] <= tag_next[i];
      end
    end
  end

  // Result register.
  assign tag_out_wide = {{TAG_PORT_W{1'b0}}, rd_tag};
  assign idx_out_wide = {{IDX_PORT_W{1'b0}}, sel};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      hit         <= hit_r;
      line_index  <= idx_out_wide[IDX_PORT_W-1:0];
      evicted     <= replace;
      evicted_tag <= replace ? tag_out_wide[TAG_PORT_W-1:0] : '0;
      hit_total   <= hits_next;
    end
  end

  assign sts.full_miss   = !any_match && !any_free;
  assign sts.scan_last   = (scan_idx == LAST_IDX);
  assign sts.out_blocked = out_valid && out_stall;

  a_commit_loads: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("commit did not load the result register");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    filled_lines <= FL_W'(LINES))
    else $error("fill count beyond line count");

  a_hit_on_valid: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && hit_r) |-> line_valid[sel])
    else $error("hit committed on an invalid line");

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb - self-checking bench for the associative tag store
// Drives block tags through the request channel and toggles the replacement
// mode between phases. A behavioral copy of the tag store predicts hit, line,
// victim and hit total for each accepted transaction. The result channel is
// compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb import acr_pkg::*;;

  localparam int LINES        = DEF_LINES;
  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 11;
  localparam int IDLE_PCT     = 6;
  localparam int SETTLE       = 12;        // idle margin before the final report
  localparam int CYCLE_LIMIT  = 4000000;
  localparam int REPORT_CAP   = 40;

  localparam logic MODE_FIFO       = 1'b0;
  localparam logic MODE_LEAST_USED = 1'b1;

  typedef struct packed {
    logic                  hit;
    logic [IDX_PORT_W-1:0] line;
    logic                  evicted;
    logic [TAG_PORT_W-1:0] old_tag;
    logic [CNT_W-1:0]      total;
  } access_result_t;

  // DUT ports; every input starts at a known value
  logic                  clk          = 1'b0;
  logic                  rst          = 1'b1;
  logic                  cfg_valid    = 1'b0;
  logic                  cfg_ready;
  logic                  replace_mode = 1'b0;
  logic                  in_valid     = 1'b0;
  logic                  in_stall;
  logic [TAG_PORT_W-1:0] block_tag    = '0;
  logic                  out_valid;
  logic                  out_stall    = 1'b0;
  logic                  hit;
  logic [IDX_PORT_W-1:0] line_index;
  logic                  evicted;
  logic [TAG_PORT_W-1:0] evicted_tag;
  logic [CNT_W-1:0]      hit_total;

  // Predicted tag store state
  logic                  line_ok    [LINES];
  logic [TAG_PORT_W-1:0] line_tag_q [LINES];
  logic [CNT_W-1:0]      use_cnt    [LINES];
  logic [2:0]            rank       [LINES];
  logic [3:0]            filled;
  logic [CNT_W-1:0]      hit_count;
  logic                  mode_q;

  access_result_t pending_results [$];

  int  mismatch_count  = 0;
  int  results_checked = 0;
  int  fifo_victims    = 0;
  int  lu_victims      = 0;
  int  cycle_count     = 0;
  bit  no_idle         = 1'b0;

  assoc_cache_tag_replacement dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .replace_mode (replace_mode),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .block_tag    (block_tag),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .hit          (hit),
    .line_index   (line_index),
    .evicted      (evicted),
    .evicted_tag  (evicted_tag),
    .hit_total    (hit_total)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // Look up one tag in the predicted store, apply the hit, fill or
  // replacement, and return the result the block must produce.
  function automatic access_result_t lookup_and_replace(input logic [TAG_PORT_W-1:0] tag);
    access_result_t   res;
    int               sel;
    logic [2:0]       r;
    logic [CNT_W-1:0] min_cnt;
    res = '0;
    sel = -1;
    for (int i = 0; i < LINES; i++)
      if (sel < 0 && line_ok[i] && line_tag_q[i] == tag) sel = i;

    if (sel >= 0) begin
      res.hit = 1'b1;
      if (hit_count != CNT_MAX) hit_count++;
      if (use_cnt[sel] != CNT_MAX) use_cnt[sel]++;
      // least-used mode: promote the line to newest among the filled lines
      if (mode_q == MODE_LEAST_USED) begin
        r = rank[sel];
        for (int i = 0; i < LINES; i++)
          if (i != sel && rank[i] > r) rank[i]--;
        rank[sel] = 3'(filled - 4'd1);
      end
    end else begin
      for (int i = 0; i < LINES; i++)
        if (sel < 0 && !line_ok[i]) sel = i;

      if (sel >= 0) begin
        // free line: take it, rank follows the line number
        line_ok[sel]    = 1'b1;
        line_tag_q[sel] = tag;
        if (use_cnt[sel] != CNT_MAX) use_cnt[sel]++;
        rank[sel] = 3'(sel);
        if (filled < 4'(LINES)) filled++;
      end else if (mode_q == MODE_FIFO) begin
        // oldest fill goes; lowest line wins a tie on rank
        sel = 0;
        for (int i = 1; i < LINES; i++)
          if (rank[i] < rank[sel]) sel = i;
        res.evicted     = 1'b1;
        res.old_tag     = line_tag_q[sel];
        line_tag_q[sel] = tag;
        rank[sel]       = 3'(LINES - 1);
        for (int i = 0; i < LINES; i++)
          if (i != sel && rank[i] > 0) rank[i]--;
        fifo_victims++;
      end else begin
        // fewest uses goes; among equal counts the oldest access goes
        sel = 0;
        for (int i = 1; i < LINES; i++)
          if (use_cnt[i] < use_cnt[sel]) sel = i;
        min_cnt = use_cnt[sel];
        for (int i = 0; i < LINES; i++)
          if (use_cnt[i] == min_cnt && rank[i] < rank[sel]) sel = i;
        res.evicted = 1'b1;
        res.old_tag = line_tag_q[sel];
        r = rank[sel];
        for (int i = 0; i < LINES; i++)
          if (i != sel && rank[i] > r) rank[i]--;
        line_tag_q[sel] = tag;
        use_cnt[sel]    = 16'd1;
        rank[sel]       = 3'(LINES - 1);
        lu_victims++;
      end
    end

    res.line  = IDX_PORT_W'(sel);
    res.total = hit_count;
    return res;
  endfunction

  // Send one tag on the request channel. Insert an occasional gap first,
  // then hold valid and the payload until the block takes the transaction.
  // Leave valid high on return so back-to-back sends never drop it.
  task automatic send_tag(input logic [TAG_PORT_W-1:0] tag);
    if (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    block_tag <= tag;
    do @(posedge clk); while (in_stall !== 1'b0);
    pending_results.push_back(lookup_and_replace(tag));
  endtask

  // Drop valid and wait until every predicted result has come back.
  task automatic drain;
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Write the mode register on the config channel while the block is idle.
  task automatic set_mode(input logic m);
    drain();
    cfg_valid    <= 1'b1;
    replace_mode <= m;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    mode_q = m;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_CAP)
        $error("%s: expected %0h, got %0h", name, want, got);
    end
  endtask

  // Take each result transaction and compare it with the oldest prediction.
  always @(posedge clk) begin : result_check
    access_result_t want;
    if (!rst && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_CAP)
          $error("result transaction with no prediction waiting");
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        check_field("hit",         32'(want.hit),     32'(hit));
        check_field("line_index",  32'(want.line),    32'(line_index));
        check_field("evicted",     32'(want.evicted), 32'(evicted));
        check_field("evicted_tag", 32'(want.old_tag), 32'(evicted_tag));
        check_field("hit_total",   32'(want.total),   32'(hit_total));
      end
    end
  end

  // Stall the result channel at random unless a burst phase is running.
  always @(posedge clk) begin
    out_stall <= !no_idle && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout: run exceeded %0d cycles", CYCLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Least-used mode straight out of reset: a zero tag must miss against the
  // cleared store, and hits with only some lines filled rank against the
  // number of filled lines.
  task automatic test_partial_fill_least_used;
    set_mode(MODE_LEAST_USED);
    send_tag(16'h0000);
    send_tag(16'hFFFF);
    send_tag(16'h0000);
    send_tag(16'hA5A5);
    send_tag(16'hFFFF);
  endtask

  // FIFO mode: hits leave ranks alone, fill the rest, then replace the
  // oldest fills.
  task automatic test_fifo_replacement;
    set_mode(MODE_FIFO);
    send_tag(16'h0000);
    send_tag(16'h0001);
    send_tag(16'h0002);
    send_tag(16'h8000);
    send_tag(16'h5A5A);
    send_tag(16'h7FFF);
    send_tag(16'h1234);
    send_tag(16'h4321);
    send_tag(16'h1234);
  endtask

  // Switch to least-used with the FIFO ranks in place and replace.
  task automatic test_least_used_replacement;
    set_mode(MODE_LEAST_USED);
    send_tag(16'h0002);
    send_tag(16'hBEEF);
    send_tag(16'hCAFE);
    send_tag(16'hBEEF);
    send_tag(16'hF00D);
  endtask

  // Random tags drawn mostly from a small working set so that hits and
  // replacements mix; the rest are resident tags and fully random tags.
  task automatic test_random_mix(input logic m, input int count, input int pool_size);
    logic [TAG_PORT_W-1:0] pool [16];
    logic [TAG_PORT_W-1:0] tag;
    int                    pick;
    int                    ln;
    set_mode(m);
    foreach (pool[i]) pool[i] = TAG_PORT_W'($urandom_range(0, 65535));
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      tag  = pool[$urandom_range(0, pool_size - 1)];
      if (pick >= 80 && pick < 90) begin
        ln = $urandom_range(0, LINES - 1);
        if (line_ok[ln]) tag = line_tag_q[ln];
      end else if (pick >= 90) begin
        tag = TAG_PORT_W'($urandom_range(0, 65535));
      end
      send_tag(tag);
    end
  endtask

  // Same mix with no gaps and no stalls on either side.
  task automatic test_back_to_back;
    drain();
    no_idle = 1'b1;
    test_random_mix(1'($urandom_range(0, 1)), 320, 9);
    drain();
    no_idle = 1'b0;
  endtask

  // Hammer one resident line so its use count climbs well above the rest,
  // then let least-used replacement run around it.
  task automatic test_hot_line;
    logic [TAG_PORT_W-1:0] tag;
    tag = line_tag_q[0];
    repeat (10) send_tag(tag);
    set_mode(MODE_LEAST_USED);
    for (int n = 0; n < 20; n++) begin
      send_tag((n % 4 == 0) ? tag : TAG_PORT_W'($urandom_range(0, 65535)));
    end
  endtask

  initial begin
    foreach (line_ok[i]) begin
      line_ok[i]    = 1'b0;
      line_tag_q[i] = '0;
      use_cnt[i]    = '0;
      rank[i]       = '0;
    end
    filled    = '0;
    hit_count = '0;
    mode_q    = MODE_FIFO;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_partial_fill_least_used();
    test_fifo_replacement();
    test_least_used_replacement();
    test_random_mix(MODE_LEAST_USED, 340, 12);
    test_random_mix(MODE_FIFO, 320, 10);
    test_random_mix(MODE_LEAST_USED, 320, 16);
    test_random_mix(MODE_FIFO, 320, 6);
    test_back_to_back();
    test_random_mix(1'($urandom_range(0, 1)), 300, 11);
    test_hot_line();

    drain();
    repeat (SETTLE) @(posedge clk);

    $display("tag store: %0d lookups checked in both modes, %0d FIFO and %0d least-used",
             results_checked, fifo_victims, lu_victims);
    $display("replacements, partial fills, mode switches and a heavily hit line covered");
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/acr_pkg.sv
hdl/acr_ctrl.sv
hdl/acr_datapath.sv
hdl/assoc_cache_tag_replacement.sv
tb/sv/tb.sv
